// ===== rtl/pei_pkg.sv =====
// Shared types, constants and saturating fixed-point helpers for the particle integrator.
// Has no dependencies; imported by the integrator top level.
package pei_pkg;

  localparam int VALUE_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int COEF_W      = 31;
  localparam int LIFE_W      = 24;
  localparam int NUM_AXES    = 3;
  localparam int PIPE_DEPTH  = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 9 * VALUE_W + LIFE_W;
  localparam int OUT_RAW_W   = 6 * VALUE_W + LIFE_W + 1;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic        [COEF_W-1:0]  coef_t;
  typedef logic        [LIFE_W-1:0]  life_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam life_t  LIFE_MAX  = {LIFE_W{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIFE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFE_ENABLE  = 3'd7;

  // Reset values
  localparam value_t RST_GRAVITY_X    = 32'sd0;
  localparam value_t RST_GRAVITY_Y    = -32'sd642253;
  localparam value_t RST_GRAVITY_Z    = 32'sd0;
  localparam coef_t  RST_DRAG         = 31'd7;
  localparam coef_t  RST_INVERSE_MASS = 31'd65536000;
  localparam coef_t  RST_TIME_STEP    = 31'd1092;
  localparam life_t  RST_MAX_LIFE     = 24'd600;

  // Clamp a value one bit wider than VALUE_W
  function automatic value_t sat_wide(input logic [VALUE_W:0] x);
    value_t r;
    if (x[VALUE_W] != x[VALUE_W-1]) begin
      r = x[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end else begin
      r = x[VALUE_W-1:0];
    end
    return r;
  endfunction

  function automatic value_t sat_add(input value_t a, input value_t b);
    logic [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    return sat_wide(s);
  endfunction

  function automatic value_t sat_sub(input value_t a, input value_t b);
    logic [VALUE_W:0] s;
    s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
    return sat_wide(s);
  endfunction

  // Floor-scale a full product back to Q format and clamp
  function automatic value_t sat_shift(input prod_t p);
    prod_t  s;
    value_t r;
    s = p >>> FRAC_BITS;
    if ((&s[PROD_W-1:VALUE_W-1]) || !(|s[PROD_W-1:VALUE_W-1])) begin
      r = s[VALUE_W-1:0];
    end else begin
      r = s[PROD_W-1] ? VALUE_MIN : VALUE_MAX;
    end
    return r;
  endfunction

endpackage

// ===== rtl/particle_euler_integrator_top.sv =====
// Streaming particle integrator: one semi-implicit Euler step with drag per request.
// Depends on pei_pkg for types, register codes and saturating arithmetic.
//
// Each request carries one particle (position, velocity, wind sampled at the
// particle, age) and produces exactly one result (new position, new velocity,
// age plus one tick, expired flag). Per axis the block computes
//   acc = gravity - inverse_mass * (drag * (vel - wind))
//   new_vel = vel + time_step * acc,  new_pos = pos + time_step * new_vel
// in Q16.16 with floor-truncated products and saturation after every step.
// The datapath is an eight-stage pipeline: one subtract stage, four 32x32
// multiply stages each followed by a scale/saturate step, and the add stages
// between them. A new particle is accepted every cycle unless the master side
// stalls; the result is valid in stage 7. Each stage has its own valid bit and
// advances whenever the stage after it is empty or advancing, so a stalled
// master side holds results in place without loss while bubbles further up
// still fill. Write configuration only while no request is in flight.
module particle_euler_integrator_top
  import pei_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, wind_x, wind_y, wind_z, life_in
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // life_out, expired, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int LAST = PIPE_DEPTH - 1;

  // Configuration registers
  value_t grav_q [NUM_AXES];
  coef_t  drag_q;
  coef_t  imass_q;
  coef_t  tstep_q;
  life_t  max_life_q;
  logic   life_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0]  <= RST_GRAVITY_X;
      grav_q[1]  <= RST_GRAVITY_Y;
      grav_q[2]  <= RST_GRAVITY_Z;
      drag_q     <= RST_DRAG;
      imass_q    <= RST_INVERSE_MASS;
      tstep_q    <= RST_TIME_STEP;
      max_life_q <= RST_MAX_LIFE;
      life_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_GRAVITY_X:    grav_q[0]  <= value_t'(cfg_wdata_i);
        CFG_GRAVITY_Y:    grav_q[1]  <= value_t'(cfg_wdata_i);
        CFG_GRAVITY_Z:    grav_q[2]  <= value_t'(cfg_wdata_i);
        CFG_DRAG:         drag_q     <= cfg_wdata_i[COEF_W-1:0];
        CFG_INVERSE_MASS: imass_q    <= cfg_wdata_i[COEF_W-1:0];
        CFG_TIME_STEP:    tstep_q    <= cfg_wdata_i[COEF_W-1:0];
        CFG_MAX_LIFE:     max_life_q <= cfg_wdata_i[LIFE_W-1:0];
        CFG_LIFE_ENABLE:  life_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Coefficients as non-negative signed operands
  value_t drag_w, imass_w, tstep_w;
  assign drag_w  = value_t'({1'b0, drag_q});
  assign imass_w = value_t'({1'b0, imass_q});
  assign tstep_w = value_t'({1'b0, tstep_q});

  // Unpack the request
  value_t in_pos_w  [NUM_AXES];
  value_t in_vel_w  [NUM_AXES];
  value_t in_wind_w [NUM_AXES];
  life_t  in_life_w;
  life_t  next_life_w;
  logic   next_exp_w;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      in_pos_w[a]  = s_axis_tdata[a * VALUE_W +: VALUE_W];
      in_vel_w[a]  = s_axis_tdata[(NUM_AXES + a) * VALUE_W +: VALUE_W];
      in_wind_w[a] = s_axis_tdata[(2 * NUM_AXES + a) * VALUE_W +: VALUE_W];
    end
    in_life_w   = s_axis_tdata[3 * NUM_AXES * VALUE_W +: LIFE_W];
    // Age saturates at the top of its range
    next_life_w = (in_life_w == LIFE_MAX) ? in_life_w : LIFE_W'(in_life_w + 1'b1);
    next_exp_w  = life_en_q && (next_life_w >= max_life_q);
  end

  // Stage handshake: a stage loads when it is empty or its successor loads
  logic [PIPE_DEPTH-1:0] v_q;
  logic [PIPE_DEPTH-1:0] adv_w;

  always_comb begin
    adv_w[LAST] = !v_q[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv_w[k] = !v_q[k] || adv_w[k+1];
    end
  end

  assign s_axis_tready = adv_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv_w[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv_w[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Datapath registers
  value_t pos_q  [PIPE_DEPTH][NUM_AXES];
  value_t vel_q  [PIPE_DEPTH][NUM_AXES];
  life_t  life_q [PIPE_DEPTH];
  logic   exp_q  [PIPE_DEPTH];
  value_t rel_q  [NUM_AXES];
  prod_t  p1_q   [NUM_AXES];
  prod_t  p2_q   [NUM_AXES];
  value_t acc_q  [NUM_AXES];
  prod_t  p3_q   [NUM_AXES];
  prod_t  p4_q   [NUM_AXES];

  always_ff @(posedge clk_i) begin
    // Stage 0: relative velocity against the wind
    if (adv_w[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        rel_q[a]    <= sat_sub(in_vel_w[a], in_wind_w[a]);
        pos_q[0][a] <= in_pos_w[a];
        vel_q[0][a] <= in_vel_w[a];
      end
      life_q[0] <= next_life_w;
      exp_q[0]  <= next_exp_w;
    end
    // Carry position, velocity and age along the line
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (adv_w[k]) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if (k != LAST) begin
            pos_q[k][a] <= pos_q[k-1][a];
          end
          if (k != 5) begin
            vel_q[k][a] <= vel_q[k-1][a];
          end
        end
        life_q[k] <= life_q[k-1];
        exp_q[k]  <= exp_q[k-1];
      end
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      // Stage 1: drag product
      if (adv_w[1]) begin
        p1_q[a] <= drag_w * rel_q[a];
      end
      // Stage 2: scale drag force by the inverse mass
      if (adv_w[2]) begin
        p2_q[a] <= imass_w * sat_shift(p1_q[a]);
      end
      // Stage 3: acceleration
      if (adv_w[3]) begin
        acc_q[a] <= sat_sub(grav_q[a], sat_shift(p2_q[a]));
      end
      // Stage 4: velocity increment
      if (adv_w[4]) begin
        p3_q[a] <= tstep_w * acc_q[a];
      end
      // Stage 5: new velocity
      if (adv_w[5]) begin
        vel_q[5][a] <= sat_add(vel_q[4][a], sat_shift(p3_q[a]));
      end
      // Stage 6: position increment
      if (adv_w[6]) begin
        p4_q[a] <= tstep_w * vel_q[5][a];
      end
      // Stage 7: new position, the output register
      if (adv_w[LAST]) begin
        pos_q[LAST][a] <= sat_add(pos_q[LAST-1][a], sat_shift(p4_q[a]));
      end
    end
  end

  // Pack the result
  assign m_axis_tvalid = v_q[LAST];

  always_comb begin
    m_axis_tdata = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      m_axis_tdata[a * VALUE_W +: VALUE_W]              = pos_q[LAST][a];
      m_axis_tdata[(NUM_AXES + a) * VALUE_W +: VALUE_W] = vel_q[LAST][a];
    end
    m_axis_tdata[2 * NUM_AXES * VALUE_W +: LIFE_W]  = life_q[LAST];
    m_axis_tdata[2 * NUM_AXES * VALUE_W + LIFE_W]   = exp_q[LAST];
  end

  // Occupancy follows the requests taken in and the results taken out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(v_q) == $countones($past(v_q))
      + int'($past(s_axis_tvalid && s_axis_tready))
      - int'($past(m_axis_tvalid && m_axis_tready))))
    else $error("pipeline occupancy does not match handshakes");

  // A held first stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !adv_w[0]) |=> (v_q[0] && $stable(life_q[0])))
    else $error("stalled first stage lost or changed its item");

  // Age advances by one tick or stays at its maximum, so it is never zero on output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2 * NUM_AXES * VALUE_W +: LIFE_W] != '0))
    else $error("result age is zero");

endmodule

// ===== tb/particle_euler_integrator_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for particle_euler_integrator_top: streams particles through the
// integrator, predicts each Euler step in Q16.16 and compares every returned field.
// Depends on pei_pkg and the integrator RTL only.
module particle_euler_integrator_top_test;
  import pei_pkg::*;

  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     PHASE_ITEMS  = 150;
  localparam int     LONG_STALL   = 400;
  localparam int     MAX_PRINTS   = 50;
  localparam longint SAT_HI       = 64'sd2147483647;
  localparam longint SAT_LO       = -64'sd2147483648;

  // Field offsets inside a request and inside a result
  localparam int VEL_OFS     = 3 * VALUE_W;
  localparam int WIND_OFS    = 6 * VALUE_W;
  localparam int AGE_OFS     = 9 * VALUE_W;
  localparam int LIFE_OFS    = 6 * VALUE_W;
  localparam int EXPIRED_BIT = 6 * VALUE_W + LIFE_W;

  typedef logic [IN_TDATA_W-1:0] particle_t;
  typedef logic [OUT_RAW_W-1:0]  step_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, wind_x, wind_y, wind_z, life_in
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // life_out, expired, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  particle_euler_integrator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the register file, kept in step with every write
  value_t grav_q [NUM_AXES] = '{RST_GRAVITY_X, RST_GRAVITY_Y, RST_GRAVITY_Z};
  coef_t  drag_q     = RST_DRAG;
  coef_t  inv_mass_q = RST_INVERSE_MASS;
  coef_t  step_q     = RST_TIME_STEP;
  life_t  life_limit = RST_MAX_LIFE;
  logic   life_on    = 1'b0;

  particle_t particle_q [$];  // particles waiting to be offered
  step_t     stepped_q [$];   // predicted results, oldest first

  int unsigned issued_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned error_cnt     = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left    = 0;
  logic        long_stall_req = 1'b0;

  // Free-running clock, 20 ns period
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Clamp an exact intermediate to the signed 32-bit range
  function automatic longint clamp_value(input longint x);
    if (x > SAT_HI) return SAT_HI;
    if (x < SAT_LO) return SAT_LO;
    return x;
  endfunction

  // Multiply by a Q16.16 coefficient, floor back to Q16.16 and saturate.
  // Operands stay within 31 x 32 bits, so the product fits a longint exactly.
  function automatic longint scale_product(input longint coef, input longint x);
    return clamp_value((coef * x) >>> FRAC_BITS);
  endfunction

  // Predict one Euler step with drag for a particle under the current registers
  function automatic step_t advance_particle(input particle_t p);
    step_t  r;
    value_t pos_f, vel_f, wind_f;
    longint rel, acc, nv, np;
    life_t  age;
    r = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      pos_f  = p[VALUE_W*a +: VALUE_W];
      vel_f  = p[VEL_OFS + VALUE_W*a +: VALUE_W];
      wind_f = p[WIND_OFS + VALUE_W*a +: VALUE_W];
      rel = clamp_value(longint'(vel_f) - longint'(wind_f));
      acc = clamp_value(longint'(grav_q[a]) -
                        scale_product(longint'(inv_mass_q),
                                      scale_product(longint'(drag_q), rel)));
      nv  = clamp_value(longint'(vel_f) + scale_product(longint'(step_q), acc));
      np  = clamp_value(longint'(pos_f) + scale_product(longint'(step_q), nv));
      r[VALUE_W*a +: VALUE_W]           = np[VALUE_W-1:0];
      r[VEL_OFS + VALUE_W*a +: VALUE_W] = nv[VALUE_W-1:0];
    end
    // Age saturates at its maximum instead of wrapping
    age = p[AGE_OFS +: LIFE_W];
    if (age != LIFE_MAX) age = age + 1'b1;
    r[LIFE_OFS +: LIFE_W] = age;
    r[EXPIRED_BIT]        = life_on && (age >= life_limit);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS)
      $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
  endtask

  // Drive one register write on the next falling edge and mirror it in the shadow
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_GRAVITY_X, CFG_GRAVITY_Y, CFG_GRAVITY_Z: grav_q[idx] = data;
      CFG_DRAG:         drag_q     = data[COEF_W-1:0];
      CFG_INVERSE_MASS: inv_mass_q = data[COEF_W-1:0];
      CFG_TIME_STEP:    step_q     = data[COEF_W-1:0];
      CFG_MAX_LIFE:     life_limit = data[LIFE_W-1:0];
      CFG_LIFE_ENABLE:  life_on    = data[0];
      default: ;
    endcase
  endtask

  // Write the whole register file back to back, then drop the write enable
  task automatic load_setting(input logic [31:0] gx, input logic [31:0] gy,
                              input logic [31:0] gz, input logic [31:0] drag_v,
                              input logic [31:0] inv_mass_v, input logic [31:0] step_v,
                              input logic [31:0] limit_v, input logic [31:0] enable_v);
    write_reg(CFG_GRAVITY_X, gx);
    write_reg(CFG_GRAVITY_Y, gy);
    write_reg(CFG_GRAVITY_Z, gz);
    write_reg(CFG_DRAG, drag_v);
    write_reg(CFG_INVERSE_MASS, inv_mass_v);
    write_reg(CFG_TIME_STEP, step_v);
    write_reg(CFG_MAX_LIFE, limit_v);
    write_reg(CFG_LIFE_ENABLE, enable_v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every queued particle went in and every predicted result came out
  task automatic drain_steps();
    while (particle_q.size() != 0 || issued_cnt != accepted_cnt || stepped_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Bias values toward the rails, zero, minus one and small magnitudes
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return $urandom_range(2097152) - 1048576;
      default: return $urandom;
    endcase
  endfunction

  // Bias ages toward the saturation point and the current expiry limit
  function automatic life_t pick_age();
    case ($urandom_range(5))
      0:       return LIFE_MAX;
      1:       return LIFE_MAX - 1'b1;
      2:       return '0;
      3:       return life_limit - 1'b1 + life_t'($urandom_range(2)) - 1'b1;
      default: return life_t'($urandom);
    endcase
  endfunction

  function automatic particle_t uniform_particle(input value_t p, input value_t v,
                                                 input value_t w, input life_t age);
    particle_t r;
    for (int a = 0; a < NUM_AXES; a++) begin
      r[VALUE_W*a +: VALUE_W]            = p;
      r[VEL_OFS + VALUE_W*a +: VALUE_W]  = v;
      r[WIND_OFS + VALUE_W*a +: VALUE_W] = w;
    end
    r[AGE_OFS +: LIFE_W] = age;
    return r;
  endfunction

  task automatic queue_random_particles(input int n);
    particle_t r;
    for (int i = 0; i < n; i++) begin
      for (int f = 0; f < 9; f++) r[VALUE_W*f +: VALUE_W] = pick_value();
      r[AGE_OFS +: LIFE_W] = pick_age();
      particle_q.push_back(r);
    end
  endtask

  // Sender: offer the next particle at the falling edge once the previous one
  // was taken; hold valid and data steady while the block stalls.
  always @(negedge clk_i) begin
    if (rst_ni && issued_cnt == accepted_cnt) begin
      if (particle_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= particle_q.pop_front();
        s_axis_tvalid <= 1'b1;
        issued_cnt++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off counted here so the
  // pipeline fills up and pushes back on the sender.
  always @(negedge clk_i) begin
    if (long_stall_req) begin
      stall_left     = LONG_STALL;
      long_stall_req = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin
    step_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        stepped_q.push_back(advance_particle(s_axis_tdata));
        accepted_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (stepped_q.size() == 0) begin
          report_mismatch("result with none expected", m_axis_tdata[31:0], '0);
        end else begin
          want = stepped_q.pop_front();
          for (int a = 0; a < NUM_AXES; a++) begin
            if (m_axis_tdata[VALUE_W*a +: VALUE_W] !== want[VALUE_W*a +: VALUE_W])
              report_mismatch($sformatf("new_pos axis %0d", a),
                              m_axis_tdata[VALUE_W*a +: VALUE_W], want[VALUE_W*a +: VALUE_W]);
            if (m_axis_tdata[VEL_OFS + VALUE_W*a +: VALUE_W] !==
                want[VEL_OFS + VALUE_W*a +: VALUE_W])
              report_mismatch($sformatf("new_vel axis %0d", a),
                              m_axis_tdata[VEL_OFS + VALUE_W*a +: VALUE_W],
                              want[VEL_OFS + VALUE_W*a +: VALUE_W]);
          end
          if (m_axis_tdata[LIFE_OFS +: LIFE_W] !== want[LIFE_OFS +: LIFE_W])
            report_mismatch("life_out", 32'(m_axis_tdata[LIFE_OFS +: LIFE_W]),
                            32'(want[LIFE_OFS +: LIFE_W]));
          if (m_axis_tdata[EXPIRED_BIT] !== want[EXPIRED_BIT])
            report_mismatch("expired", 32'(m_axis_tdata[EXPIRED_BIT]),
                            32'(want[EXPIRED_BIT]));
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("particle_euler_integrator_top verification failed");
      $finish;
    end
  end

  // Stimulus: directed particles under reset registers, then phases of random
  // particles, each phase behind a fresh register setting.
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 59;

    // Rails, sign patterns, ages at and around saturation and the default limit
    particle_q.push_back(uniform_particle('0, '0, '0, '0));
    particle_q.push_back(uniform_particle(VALUE_MAX, VALUE_MAX, VALUE_MIN, LIFE_MAX));
    particle_q.push_back(uniform_particle(VALUE_MIN, VALUE_MIN, VALUE_MAX, LIFE_MAX - 1'b1));
    particle_q.push_back(uniform_particle(VALUE_MAX, VALUE_MIN, VALUE_MIN, '0));
    particle_q.push_back(uniform_particle(VALUE_MIN, VALUE_MAX, VALUE_MAX, 24'd599));
    particle_q.push_back(uniform_particle('1, '1, '1, 24'd600));
    particle_q.push_back(uniform_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                          24'hAA_AAAA));
    particle_q.push_back(uniform_particle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                          24'h55_5555));
    particle_q.push_back(uniform_particle(32'h0001_0000, 32'h000A_0000, '0, 24'd100));
    particle_q.push_back(uniform_particle(-32'sd6553600, -32'sd3276800, 32'h0014_0000, 24'd1));
    particle_q.push_back(uniform_particle('0, 32'sd1, '0, '0));
    particle_q.push_back(uniform_particle('0, VALUE_MAX, '0, '0));
    particle_q.push_back(uniform_particle(32'h7FFF_0000, 32'h0100_0000, -32'sd1, 24'd12345));

    for (int ph = 0; ph < 10; ph++) begin
      // Registers change only with the pipeline empty
      drain_steps();
      case (ph)
        0: load_setting(32'd0, -32'sd642253, 32'd0, 32'h0000_8000, 32'h0001_0000,
                        32'd1092, 32'd600, 32'd1);
        // Every coefficient at its top, zero age limit: saturation everywhere
        1: load_setting(VALUE_MAX, VALUE_MAX, VALUE_MIN, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'd0, 32'd1);
        // No drag, zero reciprocal mass, zero step, life cycle off
        2: load_setting(VALUE_MIN, VALUE_MIN, VALUE_MIN, 32'd0, 32'd0, 32'd0,
                        32'hFFFF_FFFF, 32'hFFFF_FFFE);
        5: load_setting(32'h0001_0000, -32'sd642253, 32'hFFFF_0000, 32'h0001_0000,
                        32'h0000_8000, 32'h0000_4000, 32'd16, 32'd3);
        7: load_setting(VALUE_MIN, VALUE_MIN, VALUE_MIN, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
        default: load_setting($urandom, $urandom, $urandom,
                              (ph % 2) ? $urandom : $urandom_range(1 << 18),
                              $urandom,
                              (ph % 2) ? $urandom : $urandom_range(1 << 17),
                              $urandom_range(700), $urandom);
      endcase

      // Sender lightly idle first, then the receiver, then neither
      if (ph < 4) begin
        send_idle_pct = 9;
        recv_idle_pct = 59;
      end else if (ph < 7) begin
        send_idle_pct = 59;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph == 0) long_stall_req = 1'b1;

      if (ph == 5) begin
        // Pause the sender mid-phase until every result is back
        queue_random_particles(PHASE_ITEMS / 2);
        drain_steps();
        queue_random_particles(PHASE_ITEMS / 2);
      end else begin
        queue_random_particles(PHASE_ITEMS);
      end
    end

    drain_steps();
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (error_cnt == 0)
      $display("particle_euler_integrator_top verification clean");
    else
      $display("particle_euler_integrator_top verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pei_pkg.sv
rtl/particle_euler_integrator_top.sv
tb/particle_euler_integrator_top_test.sv
